/* rtl/jst_pkg.sv */
// shared types and constants of the json stream tokenizer
`default_nettype none

package jst_pkg;

  // token table geometry
  localparam int TOK_DEPTH = 256;
  localparam int IDX_W     = 8;

  // record queue geometry
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = 3;
  localparam int FIFO_CNT_W = 4;
  localparam int MAX_REC    = 4;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INVAL = 2'd1;
  localparam logic [1:0] ST_PART  = 2'd2;
  localparam logic [1:0] ST_NOMEM = 2'd3;

  // token kinds
  localparam logic [1:0] K_OBJ  = 2'd0;
  localparam logic [1:0] K_ARR  = 2'd1;
  localparam logic [1:0] K_STR  = 2'd2;
  localparam logic [1:0] K_PRIM = 2'd3;

  // one token table entry
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [17:0] start_pos;
    logic signed [17:0] end_pos;
    logic [7:0]         children;
    logic [8:0]         parent;
    logic [8:0]         inner;
  } entry_t;

  // one result record
  typedef struct packed {
    logic               record_kind;
    logic [7:0]         token_index;
    logic [1:0]         token_kind;
    logic signed [17:0] start_pos;
    logic signed [17:0] end_pos;
    logic [7:0]         child_count;
    logic signed [8:0]  parent_index;
    logic [8:0]         inner_count;
    logic [1:0]         status;
    logic [8:0]         token_total;
    logic               last_result;
  } rec_t;

  // table write port
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mem_wr_t;

  // up to two records written into the queue per cycle
  typedef struct packed {
    logic we0;
    logic we1;
    rec_t rec0;
    rec_t rec1;
  } fifo_push_t;

endpackage

`default_nettype wire

/* rtl/jst_token_ram.sv */
// token table memory, one write port and one registered read port
`default_nettype none

module jst_token_ram (
  input  logic                       clk,
  input  jst_pkg::mem_wr_t           wr,
  input  logic [jst_pkg::IDX_W-1:0]  rd_addr,
  output jst_pkg::entry_t            rd_data
);
  import jst_pkg::*;

  entry_t mem [TOK_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* rtl/jst_rec_fifo.sv */
// result record queue, two writes and one read per cycle; the read is held while pop_stall is high
`default_nettype none

module jst_rec_fifo (
  input  logic                            clk,
  input  logic                            rst_n,
  input  jst_pkg::fifo_push_t             push,
  input  logic                            pop_stall,
  output logic                            out_valid,
  output jst_pkg::rec_t                   out_rec,
  output logic [jst_pkg::FIFO_CNT_W-1:0]  count
);
  import jst_pkg::*;

  rec_t                  q_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wp_r, rp_r;
  logic [FIFO_CNT_W-1:0] cnt_r;
  logic                  pop;
  logic [FIFO_PTR_W-1:0] wp1;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !pop_stall;
  assign out_rec   = q_r[rp_r];
  assign count     = cnt_r;
  assign wp1       = wp_r + FIFO_PTR_W'(push.we0);

  // storage
  always_ff @(posedge clk) begin
    if (push.we0) begin
      q_r[wp_r] <= push.rec0;
    end
    if (push.we1) begin
      q_r[wp1] <= push.rec1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + FIFO_PTR_W'(push.we0) + FIFO_PTR_W'(push.we1);
      rp_r  <= rp_r + FIFO_PTR_W'(pop);
      cnt_r <= cnt_r + FIFO_CNT_W'(push.we0) + FIFO_CNT_W'(push.we1) - FIFO_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

/* rtl/json_stream_tokenizer_unit.sv */
// json stream tokenizer: byte sequencer around the token table and record queue
//
// Input channel: one text byte per request with end_of_text and restart flags.
// Restart clears the parser state before its byte is handled.
// Output channel: token records and, after a byte with end_of_text, one status
// record; last_result marks the final record a byte causes (up to four).
// Configuration: register token_capacity at byte address 0 (reset 256).
// Steps per byte: a byte inside a string, escape or hex run is accepted, then
// decoded; a byte between tokens is accepted, decoded and dispatched; a comma,
// a primitive start or a new container inside a container also waits for one
// table read. Completing a string adds the leaf write and the parent update;
// a primitive adds the same, then its delimiter is dispatched as a byte between
// tokens. A closing bracket is decoded and dispatched, then walks the parent
// links entry by entry. A byte with end_of_text adds the status record.
// Records collect in an 8-deep queue; a new byte is taken only while at least
// four slots are free, so a stalled receiver holds the input side back once
// the queue fills. Nothing is lost while out_stall is high.
// Reset clears control state and sets token_capacity to 256; the token table
// holds no reset value and is only read at entries written since restart.
`default_nettype none

module json_stream_tokenizer_unit (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_text_byte,
  input  logic               in_end_of_text,
  input  logic               in_restart,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_record_kind,
  output logic [7:0]         out_token_index,
  output logic [1:0]         out_token_kind,
  output logic signed [17:0] out_start_pos,
  output logic signed [17:0] out_end_pos,
  output logic [7:0]         out_child_count,
  output logic signed [8:0]  out_parent_index,
  output logic [8:0]         out_inner_count,
  output logic [1:0]         out_status,
  output logic [8:0]         out_token_total,
  output logic               out_last_result,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import jst_pkg::*;

  localparam logic [1:0]  REG_CAP_ADDR = 2'd0;
  localparam logic [16:0] MAX_TEXT     = 17'd65536;
  localparam logic [8:0]  NO_PARENT    = 9'h1FF;
  localparam logic [FIFO_CNT_W-1:0] CNT_LIMIT = FIFO_CNT_W'(FIFO_DEPTH - MAX_REC);

  // byte constants
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CH_D0     = 8'd48;
  localparam logic [7:0] CH_D9     = 8'd57;
  localparam logic [7:0] CH_UA     = 8'd65;
  localparam logic [7:0] CH_UF     = 8'd70;
  localparam logic [7:0] CH_LA     = 8'd97;
  localparam logic [7:0] CH_LF_HEX = 8'd102;

  typedef enum logic [2:0] {
    M_NORMAL, M_STRING, M_ESCAPE, M_HEX, M_PRIM
  } scan_mode_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_LEAF, S_LEAF_GROW, S_NORM,
    S_OPEN_PAR, S_WALK, S_COMMA, S_PRIMCHK, S_FINAL
  } state_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) || (c == CH_SPACE);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= CH_D0 && c <= CH_D9) || (c >= CH_UA && c <= CH_UF) ||
           (c >= CH_LA && c <= CH_LF_HEX);
  endfunction

  function automatic logic is_esc(input logic [7:0] c);
    return (c == CH_QUOTE) || (c == CH_SLASH) || (c == CH_BSLASH) || (c == CH_B) ||
           (c == CH_F) || (c == CH_R) || (c == CH_N) || (c == CH_T);
  endfunction

  function automatic logic is_prim_start(input logic [7:0] c);
    return (c == CH_MINUS) || (c >= CH_D0 && c <= CH_D9) ||
           (c == CH_T) || (c == CH_F) || (c == CH_N);
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic rec_t make_rec(input logic [IDX_W-1:0] idx, input entry_t e);
    rec_t r;
    r              = '0;
    r.token_index  = idx;
    r.token_kind   = e.kind;
    r.start_pos    = e.start_pos;
    r.end_pos      = e.end_pos;
    r.child_count  = e.children;
    r.parent_index = e.parent;
    r.inner_count  = e.inner;
    return r;
  endfunction

  // registers
  state_t             state_r, state_nxt;
  logic [8:0]         cap_r;
  logic [7:0]         byte_r, byte_nxt;
  logic               last_r, last_nxt;
  logic [16:0]        pos_r, pos_nxt;
  logic [8:0]         ntok_r, ntok_nxt;
  logic [8:0]         par_r, par_nxt;
  scan_mode_t         mode_r, mode_nxt;
  logic [2:0]         hex_r, hex_nxt;
  logic [16:0]        istart_r, istart_nxt;
  logic [8:0]         open_r, open_nxt;
  logic               err_r, err_nxt;
  logic [1:0]         code_r, code_nxt;
  logic [1:0]         leaf_kind_r, leaf_kind_nxt;
  logic signed [17:0] leaf_start_r, leaf_start_nxt;
  logic               norm_after_r, norm_after_nxt;
  logic [IDX_W-1:0]   wk_idx_r, wk_idx_nxt;
  rec_t               pend_r, pend_nxt;
  logic               pend_v_r, pend_v_nxt;

  // datapath signals
  logic                  accept;
  logic [FIFO_CNT_W-1:0] fifo_cnt;
  rec_t                  fifo_rec;
  fifo_push_t            fpush;
  mem_wr_t               wr;
  logic [IDX_W-1:0]      rd_addr;
  entry_t                rdata;
  logic [8:0]            eff_cap;
  logic                  tbl_full;
  logic                  par_ok;
  logic [1:0]            close_kind;
  logic [2:0]            hex_dec;
  entry_t                e_new;
  entry_t                e_mod;
  rec_t                  st_rec;
  logic [1:0]            st_code;

  logic fin, fin_inc, fin_err, fin_rec_v, push_v;
  logic [1:0] fin_code;
  rec_t fin_rec, push_rec;

  jst_token_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rdata)
  );

  jst_rec_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fpush),
    .pop_stall (out_stall),
    .out_valid (out_valid),
    .out_rec   (fifo_rec),
    .count     (fifo_cnt)
  );

  // result ports
  assign out_record_kind  = fifo_rec.record_kind;
  assign out_token_index  = fifo_rec.token_index;
  assign out_token_kind   = fifo_rec.token_kind;
  assign out_start_pos    = fifo_rec.start_pos;
  assign out_end_pos      = fifo_rec.end_pos;
  assign out_child_count  = fifo_rec.child_count;
  assign out_parent_index = fifo_rec.parent_index;
  assign out_inner_count  = fifo_rec.inner_count;
  assign out_status       = fifo_rec.status;
  assign out_token_total  = fifo_rec.token_total;
  assign out_last_result  = fifo_rec.last_result;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == REG_CAP_ADDR) ? {23'd0, cap_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 9'(TOK_DEPTH);
    end else if (psel && penable && pwrite && paddr == REG_CAP_ADDR) begin
      cap_r <= pwdata[8:0];
    end
  end

  // input handshake
  assign in_stall = (state_r != S_IDLE) || (fifo_cnt > CNT_LIMIT);
  assign accept   = in_valid && !in_stall;

  // common decode
  assign eff_cap    = (cap_r > 9'(TOK_DEPTH)) ? 9'(TOK_DEPTH) : cap_r;
  assign tbl_full   = (ntok_r >= eff_cap);
  assign par_ok     = !par_r[8];
  assign close_kind = (byte_r == CH_RBRACE) ? K_OBJ : K_ARR;
  assign hex_dec    = (hex_r != 3'd0) ? hex_r - 3'd1 : 3'd0;

  // read the current parent, or the next link while walking
  assign rd_addr = (state_r == S_WALK) ? rdata.parent[IDX_W-1:0] : par_r[IDX_W-1:0];

  // status record from the state left by the step
  always_comb begin
    if (err_r) begin
      st_code = code_r;
    end else if (mode_r != M_NORMAL || open_r != 9'd0) begin
      st_code = ST_PART;
    end else begin
      st_code = ST_OK;
    end
    st_rec             = '0;
    st_rec.record_kind = 1'b1;
    st_rec.status      = st_code;
    st_rec.token_total = (st_code == ST_OK) ? ntok_r : 9'd0;
    st_rec.last_result = 1'b1;
  end

  // byte sequencer
  always_comb begin
    state_nxt      = state_r;
    byte_nxt       = byte_r;
    last_nxt       = last_r;
    pos_nxt        = pos_r;
    ntok_nxt       = ntok_r;
    par_nxt        = par_r;
    mode_nxt       = mode_r;
    hex_nxt        = hex_r;
    istart_nxt     = istart_r;
    open_nxt       = open_r;
    err_nxt        = err_r;
    code_nxt       = code_r;
    leaf_kind_nxt  = leaf_kind_r;
    leaf_start_nxt = leaf_start_r;
    norm_after_nxt = norm_after_r;
    wk_idx_nxt     = wk_idx_r;
    pend_nxt       = pend_r;
    pend_v_nxt     = pend_v_r;
    wr             = '0;
    fpush          = '0;
    fin            = 1'b0;
    fin_inc        = 1'b0;
    fin_err        = 1'b0;
    fin_code       = ST_OK;
    fin_rec_v      = 1'b0;
    fin_rec        = '0;
    push_v         = 1'b0;
    push_rec       = '0;
    e_new          = '0;
    e_mod          = rdata;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          byte_nxt  = in_text_byte;
          last_nxt  = in_end_of_text;
          state_nxt = S_DECODE;
          if (in_restart) begin
            pos_nxt    = '0;
            ntok_nxt   = '0;
            par_nxt    = NO_PARENT;
            mode_nxt   = M_NORMAL;
            hex_nxt    = '0;
            istart_nxt = '0;
            open_nxt   = '0;
            err_nxt    = 1'b0;
            code_nxt   = ST_OK;
          end
        end
      end

      S_DECODE: begin
        if (err_r) begin
          fin = 1'b1;
        end else if (pos_r == MAX_TEXT) begin
          fin      = 1'b1;
          fin_err  = 1'b1;
          fin_code = ST_INVAL;
        end else begin
          case (mode_r)
            M_STRING: begin
              if (byte_r == CH_QUOTE) begin
                leaf_kind_nxt  = K_STR;
                leaf_start_nxt = 18'(istart_r) + 18'sd1;
                norm_after_nxt = 1'b0;
                state_nxt      = S_LEAF;
              end else begin
                if (byte_r == CH_BSLASH) begin
                  mode_nxt = M_ESCAPE;
                end
                fin     = 1'b1;
                fin_inc = 1'b1;
              end
            end
            M_ESCAPE: begin
              fin     = 1'b1;
              fin_inc = 1'b1;
              if (is_esc(byte_r)) begin
                mode_nxt = M_STRING;
              end else if (byte_r == CH_U) begin
                mode_nxt = M_HEX;
                hex_nxt  = 3'd4;
              end else begin
                fin_err  = 1'b1;
                fin_code = ST_INVAL;
              end
            end
            M_HEX: begin
              fin     = 1'b1;
              fin_inc = 1'b1;
              if (is_hex(byte_r)) begin
                hex_nxt = hex_dec;
                if (hex_dec == 3'd0) begin
                  mode_nxt = M_STRING;
                end
              end else begin
                fin_err  = 1'b1;
                fin_code = ST_INVAL;
              end
            end
            M_PRIM: begin
              if (is_ws(byte_r) || byte_r == CH_COMMA || byte_r == CH_RBRACK ||
                  byte_r == CH_RBRACE) begin
                leaf_kind_nxt  = K_PRIM;
                leaf_start_nxt = 18'(istart_r);
                norm_after_nxt = 1'b1;
                state_nxt      = S_LEAF;
              end else begin
                fin     = 1'b1;
                fin_inc = 1'b1;
                if (byte_r < CH_SPACE || byte_r >= CH_DEL) begin
                  fin_err  = 1'b1;
                  fin_code = ST_INVAL;
                end
              end
            end
            default: begin
              mode_nxt  = M_NORMAL;
              state_nxt = S_NORM;
            end
          endcase
        end
      end

      // write the finished string or primitive
      S_LEAF: begin
        if (tbl_full) begin
          fin      = 1'b1;
          fin_inc  = 1'b1;
          fin_err  = 1'b1;
          fin_code = ST_NOMEM;
        end else begin
          e_new.kind      = leaf_kind_r;
          e_new.start_pos = leaf_start_r;
          e_new.end_pos   = 18'(pos_r);
          e_new.parent    = par_r;
          wr.en           = 1'b1;
          wr.addr         = ntok_r[IDX_W-1:0];
          wr.data         = e_new;
          ntok_nxt        = ntok_r + 9'd1;
          if (par_ok) begin
            push_v    = 1'b1;
            push_rec  = make_rec(ntok_r[IDX_W-1:0], e_new);
            state_nxt = S_LEAF_GROW;
          end else begin
            mode_nxt = M_NORMAL;
            if (norm_after_r) begin
              push_v    = 1'b1;
              push_rec  = make_rec(ntok_r[IDX_W-1:0], e_new);
              state_nxt = S_NORM;
            end else begin
              fin       = 1'b1;
              fin_inc   = 1'b1;
              fin_rec_v = 1'b1;
              fin_rec   = make_rec(ntok_r[IDX_W-1:0], e_new);
            end
          end
        end
      end

      // count the leaf in its parent
      S_LEAF_GROW: begin
        e_mod.children = sat_inc(rdata.children);
        wr.en          = 1'b1;
        wr.addr        = par_r[IDX_W-1:0];
        wr.data        = e_mod;
        mode_nxt       = M_NORMAL;
        if (norm_after_r) begin
          push_v    = 1'b1;
          push_rec  = make_rec(par_r[IDX_W-1:0], e_mod);
          state_nxt = S_NORM;
        end else begin
          fin       = 1'b1;
          fin_inc   = 1'b1;
          fin_rec_v = 1'b1;
          fin_rec   = make_rec(par_r[IDX_W-1:0], e_mod);
        end
      end

      // byte between tokens
      S_NORM: begin
        case (byte_r)
          CH_LBRACE, CH_LBRACK: begin
            if (tbl_full) begin
              fin      = 1'b1;
              fin_inc  = 1'b1;
              fin_err  = 1'b1;
              fin_code = ST_NOMEM;
            end else begin
              e_new.kind      = (byte_r == CH_LBRACE) ? K_OBJ : K_ARR;
              e_new.start_pos = 18'(pos_r);
              e_new.end_pos   = -18'sd1;
              e_new.parent    = par_r;
              e_new.inner     = ntok_r + 9'd1;
              wr.en           = 1'b1;
              wr.addr         = ntok_r[IDX_W-1:0];
              wr.data         = e_new;
              ntok_nxt        = ntok_r + 9'd1;
              par_nxt         = {1'b0, ntok_r[IDX_W-1:0]};
              open_nxt        = open_r + 9'd1;
              wk_idx_nxt      = par_r[IDX_W-1:0];
              if (par_ok) begin
                push_v    = 1'b1;
                push_rec  = make_rec(ntok_r[IDX_W-1:0], e_new);
                state_nxt = S_OPEN_PAR;
              end else begin
                fin       = 1'b1;
                fin_inc   = 1'b1;
                fin_rec_v = 1'b1;
                fin_rec   = make_rec(ntok_r[IDX_W-1:0], e_new);
              end
            end
          end
          CH_RBRACE, CH_RBRACK: begin
            if (ntok_r == 9'd0 || !par_ok) begin
              fin      = 1'b1;
              fin_inc  = 1'b1;
              fin_err  = 1'b1;
              fin_code = ST_INVAL;
            end else begin
              wk_idx_nxt = par_r[IDX_W-1:0];
              state_nxt  = S_WALK;
            end
          end
          CH_QUOTE: begin
            mode_nxt   = M_STRING;
            istart_nxt = pos_r;
            fin        = 1'b1;
            fin_inc    = 1'b1;
          end
          CH_TAB, CH_LF, CH_CR, CH_SPACE: begin
            fin     = 1'b1;
            fin_inc = 1'b1;
          end
          CH_COLON: begin
            par_nxt = ntok_r - 9'd1;
            fin     = 1'b1;
            fin_inc = 1'b1;
          end
          CH_COMMA: begin
            if (par_ok) begin
              state_nxt = S_COMMA;
            end else begin
              fin     = 1'b1;
              fin_inc = 1'b1;
            end
          end
          default: begin
            if (is_prim_start(byte_r)) begin
              if (par_ok) begin
                state_nxt = S_PRIMCHK;
              end else begin
                mode_nxt   = M_PRIM;
                istart_nxt = pos_r;
                fin        = 1'b1;
                fin_inc    = 1'b1;
              end
            end else begin
              fin      = 1'b1;
              fin_inc  = 1'b1;
              fin_err  = 1'b1;
              fin_code = ST_INVAL;
            end
          end
        endcase
      end

      // count the new container in its parent
      S_OPEN_PAR: begin
        e_mod.children = sat_inc(rdata.children);
        wr.en          = 1'b1;
        wr.addr        = wk_idx_r;
        wr.data        = e_mod;
        fin            = 1'b1;
        fin_inc        = 1'b1;
        fin_rec_v      = 1'b1;
        fin_rec        = make_rec(wk_idx_r, e_mod);
      end

      // comma after a key-value pair leaves the key
      S_COMMA: begin
        if (rdata.kind == K_STR || rdata.kind == K_PRIM) begin
          par_nxt = rdata.parent;
        end
        fin     = 1'b1;
        fin_inc = 1'b1;
      end

      // a primitive may not stand as a key
      S_PRIMCHK: begin
        fin     = 1'b1;
        fin_inc = 1'b1;
        if (rdata.kind == K_OBJ || (rdata.kind == K_STR && rdata.children != 8'd0)) begin
          fin_err  = 1'b1;
          fin_code = ST_INVAL;
        end else begin
          mode_nxt   = M_PRIM;
          istart_nxt = pos_r;
        end
      end

      // walk parent links to the matching container
      S_WALK: begin
        if (rdata.start_pos != -18'sd1 && rdata.kind == close_kind) begin
          if (rdata.end_pos == -18'sd1 && open_r != 9'd0) begin
            open_nxt = open_r - 9'd1;
          end
          e_mod.end_pos = 18'(pos_r) + 18'sd1;
          e_mod.inner   = ntok_r - rdata.inner;
          par_nxt       = rdata.parent;
          wr.en         = 1'b1;
          wr.addr       = wk_idx_r;
          wr.data       = e_mod;
          fin           = 1'b1;
          fin_inc       = 1'b1;
          fin_rec_v     = 1'b1;
          fin_rec       = make_rec(wk_idx_r, e_mod);
        end else if (rdata.parent[8]) begin
          fin      = 1'b1;
          fin_inc  = 1'b1;
          fin_err  = 1'b1;
          fin_code = ST_INVAL;
        end else begin
          wk_idx_nxt = rdata.parent[IDX_W-1:0];
        end
      end

      S_FINAL: begin
        fpush.we0  = 1'b1;
        fpush.rec0 = st_rec;
        state_nxt  = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // end of the byte: advance position, latch error, drain records
    if (fin) begin
      if (fin_inc) begin
        pos_nxt = pos_r + 17'd1;
      end
      if (fin_err) begin
        err_nxt  = 1'b1;
        code_nxt = fin_code;
      end
      fpush.we0  = pend_v_r;
      fpush.rec0 = pend_r;
      if (fin_rec_v) begin
        fpush.we1              = 1'b1;
        fpush.rec1             = fin_rec;
        fpush.rec1.last_result = !last_r;
      end else begin
        fpush.rec0.last_result = !last_r;
      end
      pend_v_nxt = 1'b0;
      state_nxt  = last_r ? S_FINAL : S_IDLE;
    end else if (push_v) begin
      fpush.we0  = pend_v_r;
      fpush.rec0 = pend_r;
      pend_nxt   = push_rec;
      pend_v_nxt = 1'b1;
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pos_r    <= '0;
      ntok_r   <= '0;
      par_r    <= NO_PARENT;
      mode_r   <= M_NORMAL;
      hex_r    <= '0;
      istart_r <= '0;
      open_r   <= '0;
      err_r    <= 1'b0;
      code_r   <= ST_OK;
      pend_v_r <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      ntok_r   <= ntok_nxt;
      par_r    <= par_nxt;
      mode_r   <= mode_nxt;
      hex_r    <= hex_nxt;
      istart_r <= istart_nxt;
      open_r   <= open_nxt;
      err_r    <= err_nxt;
      code_r   <= code_nxt;
      pend_v_r <= pend_v_nxt;
      last_r   <= last_nxt;
    end
    byte_r       <= byte_nxt;
    leaf_kind_r  <= leaf_kind_nxt;
    leaf_start_r <= leaf_start_nxt;
    norm_after_r <= norm_after_nxt;
    wk_idx_r     <= wk_idx_nxt;
    pend_r       <= pend_nxt;
  end

  // record queue never overflows
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("record queue overflow");

  // a request is only taken between bytes
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> state_r == S_IDLE && !pend_v_r)
    else $error("byte accepted while busy");

  // a taken request is decoded next
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_DECODE)
    else $error("accepted byte not decoded");

  // no held record survives the end of a byte
  a_pend_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FINAL |-> !pend_v_r)
    else $error("record left pending at status");

endmodule

`default_nettype wire
